// ===== src/rgblpp_pkg.sv =====
// shared types and constants of the rgb led pattern player
package rgblpp_pkg;

    // pattern memory geometry
    localparam int PATTERN_DEPTH = 256;
    localparam int DURATION_BITS = 16;
    localparam int LEVEL_BITS    = 8;

    localparam int PTR_W  = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;
    localparam int LEN_W  = $clog2(PATTERN_DEPTH + 1);
    localparam int ADDR_W = PTR_W + 1;
    localparam int MEM_WORDS = 2 ** ADDR_W;

    localparam logic [7:0] ENDLESS_REPEAT = 8'd255;

    // item modes
    typedef enum logic [1:0] {
        MODE_LOAD   = 2'd0,
        MODE_START  = 2'd1,
        MODE_CANCEL = 2'd2,
        MODE_TICK   = 2'd3
    } mode_t;

    // start outcome
    typedef enum logic [1:0] {
        ST_NONE     = 2'd0,
        ST_ACCEPTED = 2'd1,
        ST_DISABLED = 2'd2,
        ST_BUSY     = 2'd3
    } status_t;

    // register index, taken from paddr[2]
    localparam logic REG_ENABLE_NORMAL = 1'b0;
    localparam logic REG_ENABLE_URGENT = 1'b1;

    // one pattern entry
    typedef struct packed {
        logic [LEVEL_BITS-1:0]    red;
        logic [LEVEL_BITS-1:0]    green;
        logic [LEVEL_BITS-1:0]    blue;
        logic [DURATION_BITS-1:0] duration;
    } entry_t;

endpackage

// ===== src/rgb_led_pattern_player.sv =====
// rgb led pattern player: two-bank pattern memory, playback sequencer and apb registers
//
// Plays a stored RGB pattern. Every transfer on the s_ channel yields exactly one
// transfer on the m_ channel carrying the drive levels, busy flag, start status and
// finished pulse as they stand after that item. One item is taken per clock unless the
// result channel stalls; a result waits in the middle stage for the registered read of
// the shown entry from the pattern memory, then moves to the output register. Loads
// always go to the bank that is not playing; an accepted start swaps banks. The
// pattern memory has no reset and no clearing pass: an entry read before it was
// loaded gives undefined levels and duration. enable_normal sits at byte address 0
// and enable_urgent at 4; both reset to 1 and are to be written only while idle.
module rgb_led_pattern_player (
    input  logic        aclk,
    input  logic        aresetn,

    // apb configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    // item input channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_mode,
    input  logic [7:0]  s_entry_index,
    input  logic [7:0]  s_level_red,
    input  logic [7:0]  s_level_green,
    input  logic [7:0]  s_level_blue,
    input  logic [15:0] s_duration,
    input  logic [8:0]  s_pattern_length,
    input  logic [7:0]  s_repeat_count,
    input  logic        s_urgent,

    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_drive_red,
    output logic [7:0]  m_drive_green,
    output logic [7:0]  m_drive_blue,
    output logic        m_busy_res,
    output logic [1:0]  m_start_status,
    output logic        m_finished
);
    import rgblpp_pkg::*;

    // configuration
    logic enable_normal_reg;
    logic enable_urgent_reg;

    // playback state
    logic                     play_bank_reg,  play_bank_next;
    logic                     playing_reg,    playing_next;
    logic [PTR_W-1:0]         ptr_reg,        ptr_next;
    logic [DURATION_BITS-1:0] ticks_reg,      ticks_next;
    logic                     fresh_reg,      fresh_next;
    logic [7:0]               rounds_reg,     rounds_next;
    logic [LEN_W-1:0]         act_len_reg,    act_len_next;
    logic [7:0]               act_rep_reg,    act_rep_next;

    // pattern memory, registered read
    entry_t                   mem [MEM_WORDS];
    entry_t                   rd_reg;
    logic                     rd_en;
    logic [ADDR_W-1:0]        rd_addr;
    logic                     wr_en;
    logic [ADDR_W-1:0]        wr_addr;
    entry_t                   wr_data;

    // middle stage: item done, waiting for the memory read
    logic                     mid_valid_reg;
    logic                     mid_busy_reg;
    status_t                  mid_status_reg;
    logic                     mid_finished_reg;
    logic                     mid_advance;

    // output register
    logic                     m_valid_reg;
    logic [7:0]               m_red_reg;
    logic [7:0]               m_green_reg;
    logic [7:0]               m_blue_reg;
    logic                     m_busy_reg;
    status_t                  m_status_reg;
    logic                     m_finished_reg;

    // per-item decisions
    logic                     s_accept;
    status_t                  status_next;
    logic                     finished_next;
    logic                     do_stop;
    logic                     show;
    logic                     allowed;
    logic [DURATION_BITS-1:0] cur_ticks;
    logic [7:0]               rounds_inc;
    logic [LEN_W-1:0]         len_sat;

    // ---------------------------------------------------------------
    // apb registers: write on the access phase, reads are combinational
    // ---------------------------------------------------------------
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_normal_reg <= 1'b1;
            enable_urgent_reg <= 1'b1;
        end else if (psel && penable && pwrite && pready) begin
            unique case (paddr[2])
                REG_ENABLE_NORMAL: enable_normal_reg <= pwdata[0];
                REG_ENABLE_URGENT: enable_urgent_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = 32'd0;
        unique case (paddr[2])
            REG_ENABLE_NORMAL: prdata[0] = enable_normal_reg;
            REG_ENABLE_URGENT: prdata[0] = enable_urgent_reg;
            default: ;
        endcase
    end

    // ---------------------------------------------------------------
    // handshake: an item can enter whenever the middle stage is empty or can drain
    // ---------------------------------------------------------------
    assign mid_advance = mid_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready     = !mid_valid_reg || !m_valid_reg || m_ready;
    assign s_accept    = s_valid && s_ready;

    // ticks left of the shown entry; straight after a show it still sits
    // in the memory read register, zero counting as one
    always_comb begin
        if (fresh_reg) begin
            cur_ticks = (rd_reg.duration == '0) ? DURATION_BITS'(1) : rd_reg.duration;
        end else begin
            cur_ticks = ticks_reg;
        end
    end

    assign rounds_inc = rounds_reg + 8'd1;
    assign len_sat    = (32'(s_pattern_length) > PATTERN_DEPTH)
                        ? LEN_W'(PATTERN_DEPTH) : LEN_W'(s_pattern_length);
    assign allowed    = s_urgent ? enable_urgent_reg : enable_normal_reg;

    // ---------------------------------------------------------------
    // sequencer next state
    // ---------------------------------------------------------------
    always_comb begin
        play_bank_next = play_bank_reg;
        playing_next   = playing_reg;
        ptr_next       = ptr_reg;
        ticks_next     = ticks_reg;
        fresh_next     = fresh_reg;
        rounds_next    = rounds_reg;
        act_len_next   = act_len_reg;
        act_rep_next   = act_rep_reg;
        status_next    = ST_NONE;
        finished_next  = 1'b0;
        do_stop        = 1'b0;
        show           = 1'b0;
        wr_en          = 1'b0;

        if (s_accept) begin
            unique case (mode_t'(s_mode))
                MODE_LOAD: begin
                    wr_en = (32'(s_entry_index) < PATTERN_DEPTH);
                end
                MODE_START: begin
                    if (!allowed) begin
                        status_next = ST_DISABLED;
                    end else if (!s_urgent && playing_reg) begin
                        status_next = ST_BUSY;
                    end else begin
                        // an urgent start over a running pattern ends it first
                        status_next    = ST_ACCEPTED;
                        finished_next  = playing_reg;
                        play_bank_next = ~play_bank_reg;
                        act_len_next   = len_sat;
                        act_rep_next   = s_repeat_count;
                        if (len_sat == '0 || s_repeat_count == 8'd0) begin
                            do_stop       = 1'b1;
                            finished_next = 1'b1;
                        end else begin
                            playing_next = 1'b1;
                            ptr_next     = '0;
                            rounds_next  = 8'd0;
                            show         = 1'b1;
                        end
                    end
                end
                MODE_CANCEL: begin
                    if (playing_reg) begin
                        do_stop       = 1'b1;
                        finished_next = 1'b1;
                    end
                end
                MODE_TICK: begin
                    if (playing_reg) begin
                        if (cur_ticks <= DURATION_BITS'(1)) begin
                            if ((32'(ptr_reg) + 32'd1) < 32'(act_len_reg)) begin
                                ptr_next = ptr_reg + PTR_W'(1);
                                show     = 1'b1;
                            end else if (act_rep_reg != ENDLESS_REPEAT &&
                                         rounds_inc >= act_rep_reg) begin
                                do_stop       = 1'b1;
                                finished_next = 1'b1;
                            end else begin
                                // next round from the first entry
                                if (act_rep_reg != ENDLESS_REPEAT) begin
                                    rounds_next = rounds_inc;
                                end
                                ptr_next = '0;
                                show     = 1'b1;
                            end
                        end else begin
                            ticks_next = cur_ticks - DURATION_BITS'(1);
                            fresh_next = 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end

        if (show) begin
            fresh_next = 1'b1;
        end

        if (do_stop) begin
            playing_next = 1'b0;
            ptr_next     = '0;
            ticks_next   = '0;
            fresh_next   = 1'b0;
            rounds_next  = 8'd0;
        end
    end

    assign rd_en   = show;
    assign rd_addr = {play_bank_next, ptr_next};

    // loads go to the bank that is not playing
    assign wr_addr        = {~play_bank_reg, PTR_W'(s_entry_index)};
    assign wr_data.red      = LEVEL_BITS'(s_level_red);
    assign wr_data.green    = LEVEL_BITS'(s_level_green);
    assign wr_data.blue     = LEVEL_BITS'(s_level_blue);
    assign wr_data.duration = DURATION_BITS'(s_duration);

    // ---------------------------------------------------------------
    // pattern memory
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_reg <= mem[rd_addr];
        end
    end

    // ---------------------------------------------------------------
    // state registers
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            play_bank_reg <= 1'b0;
            playing_reg   <= 1'b0;
            ptr_reg       <= '0;
            ticks_reg     <= '0;
            fresh_reg     <= 1'b0;
            rounds_reg    <= 8'd0;
            act_len_reg   <= '0;
            act_rep_reg   <= 8'd0;
        end else begin
            play_bank_reg <= play_bank_next;
            playing_reg   <= playing_next;
            ptr_reg       <= ptr_next;
            ticks_reg     <= ticks_next;
            fresh_reg     <= fresh_next;
            rounds_reg    <= rounds_next;
            act_len_reg   <= act_len_next;
            act_rep_reg   <= act_rep_next;
        end
    end

    // ---------------------------------------------------------------
    // middle stage: holds the item's flags until the entry read lands
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mid_valid_reg <= 1'b0;
        end else if (s_accept) begin
            mid_valid_reg <= 1'b1;
        end else if (mid_advance) begin
            mid_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            mid_busy_reg     <= playing_next;
            mid_status_reg   <= status_next;
            mid_finished_reg <= finished_next;
        end
    end

    // ---------------------------------------------------------------
    // output register; drive is off whenever nothing is playing
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (mid_advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (mid_advance) begin
            m_red_reg      <= mid_busy_reg ? 8'(rd_reg.red)   : 8'd0;
            m_green_reg    <= mid_busy_reg ? 8'(rd_reg.green) : 8'd0;
            m_blue_reg     <= mid_busy_reg ? 8'(rd_reg.blue)  : 8'd0;
            m_busy_reg     <= mid_busy_reg;
            m_status_reg   <= mid_status_reg;
            m_finished_reg <= mid_finished_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_drive_red    = m_red_reg;
    assign m_drive_green  = m_green_reg;
    assign m_drive_blue   = m_blue_reg;
    assign m_busy_res     = m_busy_reg;
    assign m_start_status = m_status_reg;
    assign m_finished     = m_finished_reg;

endmodule

// ===== tb/sv/rgblpp_check_pkg.sv =====
// expected-frame board for the rgb led pattern player: item and frame types plus playback predictor
`timescale 1ns / 1ps

package rgblpp_check_pkg;

    import rgblpp_pkg::*;

    typedef struct packed {
        mode_t                    mode;
        logic [PTR_W-1:0]         entry_index;
        logic [LEVEL_BITS-1:0]    red;
        logic [LEVEL_BITS-1:0]    green;
        logic [LEVEL_BITS-1:0]    blue;
        logic [DURATION_BITS-1:0] duration;
        logic [LEN_W-1:0]         pattern_length;
        logic [7:0]               repeat_count;
        logic                     urgent;
    } led_item_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       busy;
        status_t    status;
        logic       finished;
    } led_frame_t;

    class led_frame_board;
        int unsigned mismatches;

        logic en_normal;
        logic en_urgent;

        // two banks of pattern entries, plus which entries have been loaded
        logic [3*LEVEL_BITS-1:0]  colour_mem [MEM_WORDS];
        logic [DURATION_BITS-1:0] hold_mem   [MEM_WORDS];
        bit                       loaded     [MEM_WORDS];

        logic                     play_bank;
        logic                     playing;
        logic [PTR_W-1:0]         entry_ptr;
        logic [DURATION_BITS-1:0] ticks_left;
        logic [7:0]               rounds_done;
        logic [LEN_W-1:0]         active_len;
        logic [7:0]               active_repeat;
        logic [3*LEVEL_BITS-1:0]  drive;

        led_frame_t due_frames [$];

        function new();
            mismatches = 0;
            en_normal  = 1'b1;
            en_urgent  = 1'b1;
            foreach (loaded[i]) begin
                loaded[i]     = 1'b0;
                colour_mem[i] = '0;
                hold_mem[i]   = '0;
            end
            play_bank     = 1'b0;
            active_len    = '0;
            active_repeat = '0;
            halt();
        endfunction

        function void halt();
            playing     = 1'b0;
            drive       = '0;
            entry_ptr   = '0;
            ticks_left  = '0;
            rounds_done = '0;
        endfunction

        // put the current entry of the playing bank on the drive
        function void show_step();
            logic [ADDR_W-1:0] slot;
            slot       = {play_bank, entry_ptr};
            drive      = colour_mem[slot];
            ticks_left = (hold_mem[slot] == '0) ? DURATION_BITS'(1) : hold_mem[slot];
        endfunction

        function void set_reg(logic idx, logic value);
            if (idx == REG_ENABLE_NORMAL)
                en_normal = value;
            else
                en_urgent = value;
        endfunction

        function bit start_runs(logic urg);
            return urg ? en_urgent : (en_normal && !playing);
        endfunction

        // loaded entries counted from zero in the bank a start would switch to
        function int unsigned ready_entries();
            int unsigned n;
            n = 0;
            while (n < PATTERN_DEPTH && loaded[{~play_bank, PTR_W'(n)}])
                n++;
            return n;
        endfunction

        function int unsigned pending();
            return due_frames.size();
        endfunction

        function void take_item(led_item_t it);
            led_frame_t        f;
            logic [ADDR_W-1:0] slot;
            logic              allowed;
            bit                finishing;
            f.status   = ST_NONE;
            f.finished = 1'b0;
            case (it.mode)
                MODE_LOAD: begin
                    slot             = {~play_bank, it.entry_index};
                    colour_mem[slot] = {it.red, it.green, it.blue};
                    hold_mem[slot]   = it.duration;
                    loaded[slot]     = 1'b1;
                end
                MODE_START: begin
                    allowed = it.urgent ? en_urgent : en_normal;
                    if (!allowed) begin
                        f.status = ST_DISABLED;
                    end else if (!it.urgent && playing) begin
                        f.status = ST_BUSY;
                    end else begin
                        f.status = ST_ACCEPTED;
                        if (playing) begin
                            halt();
                            f.finished = 1'b1;
                        end
                        play_bank     = ~play_bank;
                        active_len    = (32'(it.pattern_length) > PATTERN_DEPTH) ?
                                        LEN_W'(PATTERN_DEPTH) : it.pattern_length;
                        active_repeat = it.repeat_count;
                        if (active_len == '0 || active_repeat == '0) begin
                            halt();
                            f.finished = 1'b1;
                        end else begin
                            playing     = 1'b1;
                            entry_ptr   = '0;
                            rounds_done = '0;
                            show_step();
                        end
                    end
                end
                MODE_CANCEL: begin
                    if (playing) begin
                        halt();
                        f.finished = 1'b1;
                    end
                end
                default: begin
                    if (playing) begin
                        if (ticks_left != '0)
                            ticks_left = ticks_left - DURATION_BITS'(1);
                        if (ticks_left == '0) begin
                            if (LEN_W'(entry_ptr) + LEN_W'(1) < active_len) begin
                                entry_ptr = entry_ptr + PTR_W'(1);
                                show_step();
                            end else begin
                                finishing = 1'b0;
                                if (active_repeat != ENDLESS_REPEAT) begin
                                    rounds_done = rounds_done + 8'd1;
                                    finishing   = (rounds_done >= active_repeat);
                                end
                                if (finishing) begin
                                    halt();
                                    f.finished = 1'b1;
                                end else begin
                                    entry_ptr = '0;
                                    show_step();
                                end
                            end
                        end
                    end
                end
            endcase
            f.red   = drive[2*LEVEL_BITS +: LEVEL_BITS];
            f.green = drive[LEVEL_BITS +: LEVEL_BITS];
            f.blue  = drive[0 +: LEVEL_BITS];
            f.busy  = playing;
            due_frames.push_back(f);
        endfunction

        function void match_field(string what, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                mismatches++;
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
            end
        endfunction

        function void match_frame(led_frame_t got);
            led_frame_t want;
            if (due_frames.size() == 0) begin
                mismatches++;
                $display("%0t: result transfer with nothing expected", $time);
                return;
            end
            want = due_frames.pop_front();
            match_field("drive_red", 32'(want.red), 32'(got.red));
            match_field("drive_green", 32'(want.green), 32'(got.green));
            match_field("drive_blue", 32'(want.blue), 32'(got.blue));
            match_field("busy_res", 32'(want.busy), 32'(got.busy));
            match_field("start_status", 32'(want.status), 32'(got.status));
            match_field("finished", 32'(want.finished), 32'(got.finished));
        endfunction
    endclass

endpackage

// ===== tb/sv/rgb_led_pattern_player_test.sv =====
// self-checking testbench for the rgb led pattern player
`timescale 1ns / 1ps

module rgb_led_pattern_player_test;

    import rgblpp_pkg::*;
    import rgblpp_check_pkg::*;

    // cycles without any transfer before the run is declared hung
    localparam int QUIET_LIMIT = 2000;
    // length of the one long receiver hold-off
    localparam int HOLD_OFF_CYCLES = 300;

    logic        aclk = 1'b0;
    logic        aresetn;

    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_mode;
    logic [7:0]  s_entry_index;
    logic [7:0]  s_level_red;
    logic [7:0]  s_level_green;
    logic [7:0]  s_level_blue;
    logic [15:0] s_duration;
    logic [8:0]  s_pattern_length;
    logic [7:0]  s_repeat_count;
    logic        s_urgent;

    logic        m_valid;
    logic        m_ready;
    logic [7:0]  m_drive_red;
    logic [7:0]  m_drive_green;
    logic [7:0]  m_drive_blue;
    logic        m_busy_res;
    logic [1:0]  m_start_status;
    logic        m_finished;

    led_frame_board board;

    // sender pacing: items left in the current burst and the widest gap between bursts
    int unsigned burst_left = 0;
    int unsigned gap_max    = 0;
    // input transfers so far
    int unsigned items_sent = 0;
    // asks the receiver for its long hold-off
    bit          hold_request = 1'b0;

    rgb_led_pattern_player u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_mode           (s_mode),
        .s_entry_index    (s_entry_index),
        .s_level_red      (s_level_red),
        .s_level_green    (s_level_green),
        .s_level_blue     (s_level_blue),
        .s_duration       (s_duration),
        .s_pattern_length (s_pattern_length),
        .s_repeat_count   (s_repeat_count),
        .s_urgent         (s_urgent),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_drive_red      (m_drive_red),
        .m_drive_green    (m_drive_green),
        .m_drive_blue     (m_drive_blue),
        .m_busy_res       (m_busy_res),
        .m_start_status   (m_start_status),
        .m_finished       (m_finished)
    );

    // 50 MHz clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // every field random, so that don't-care bits toggle too
    function automatic led_item_t rand_item(input mode_t m);
        led_item_t it;
        it.mode           = m;
        it.entry_index    = 8'($urandom);
        it.red            = 8'($urandom);
        it.green          = 8'($urandom);
        it.blue           = 8'($urandom);
        it.duration       = 16'($urandom);
        it.pattern_length = 9'($urandom);
        it.repeat_count   = 8'($urandom);
        it.urgent         = 1'($urandom);
        return it;
    endfunction

    // mostly short entry durations, now and then a long or a full-range one
    function automatic logic [DURATION_BITS-1:0] short_hold();
        case ($urandom_range(19))
            0:       return DURATION_BITS'($urandom);
            1, 2, 3: return DURATION_BITS'($urandom_range(15, 4));
            default: return DURATION_BITS'($urandom_range(3));
        endcase
    endfunction

    // offer one item on the s_ channel, called and returning at a falling edge
    task automatic offer(input led_item_t it);
        // a burst has run out: drop valid for a random gap, then start the next burst
        if (burst_left == 0) begin
            if (gap_max > 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(gap_max, 1)) @(negedge aclk);
            end
            burst_left = $urandom_range(24, 1);
        end
        burst_left--;
        s_valid          <= 1'b1;
        s_mode           <= it.mode;
        s_entry_index    <= it.entry_index;
        s_level_red      <= it.red;
        s_level_green    <= it.green;
        s_level_blue     <= it.blue;
        s_duration       <= it.duration;
        s_pattern_length <= it.pattern_length;
        s_repeat_count   <= it.repeat_count;
        s_urgent         <= it.urgent;
        // hold the payload until the transfer happens
        do
            @(posedge aclk);
        while (!s_ready);
        @(negedge aclk);
        items_sent++;
    endtask

    task automatic send_load(input logic [7:0] idx, input logic [7:0] r, input logic [7:0] g,
                             input logic [7:0] b, input logic [DURATION_BITS-1:0] hold);
        led_item_t it;
        it             = rand_item(MODE_LOAD);
        it.entry_index = idx;
        it.red         = r;
        it.green       = g;
        it.blue        = b;
        it.duration    = hold;
        offer(it);
    endtask

    // a start that would run is cut down to the entries already loaded in the
    // bank it switches to, so playback never shows an entry that was never written
    task automatic send_start(input int unsigned len, input int unsigned rep, input logic urg);
        led_item_t   it;
        int unsigned need;
        it   = rand_item(MODE_START);
        need = (len > PATTERN_DEPTH) ? PATTERN_DEPTH : len;
        if (board.start_runs(urg) && need > board.ready_entries())
            len = board.ready_entries();
        it.pattern_length = LEN_W'(len);
        it.repeat_count   = 8'(rep);
        it.urgent         = urg;
        offer(it);
    endtask

    task automatic send_simple(input mode_t m);
        offer(rand_item(m));
    endtask

    // stop offering, let every expected result arrive and the pipeline settle
    task automatic drain();
        s_valid    <= 1'b0;
        burst_left = 0;
        while (board.pending() != 0)
            @(negedge aclk);
        repeat (6) @(negedge aclk);
    endtask

    // apb write (setup then access) followed by a read-back of the same register
    task automatic write_reg(input logic idx, input logic value);
        paddr   <= {idx, 2'b00};
        pwdata  <= {31'd0, value};
        pwrite  <= 1'b1;
        psel    <= 1'b1;
        penable <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        // register took the value at the rising edge just passed
        board.set_reg(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
        psel    <= 1'b1;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        board.match_field("prdata", {31'd0, value}, prdata);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // registers only change once the block is idle
    task automatic set_enables(input logic normal_on, input logic urgent_on);
        drain();
        write_reg(REG_ENABLE_NORMAL, normal_on);
        write_reg(REG_ENABLE_URGENT, urgent_on);
    endtask

    // random traffic: mostly load-then-play sequences, the rest loose items
    task automatic run_random(input int unsigned target);
        int unsigned n;
        int unsigned k;
        int unsigned len;
        int unsigned rep;
        mode_t       m;
        while (items_sent < target) begin
            // sender pacing for this sequence, including stretches with no gaps
            case ($urandom_range(4))
                0, 1:    gap_max = 0;
                2:       gap_max = 3;
                3:       gap_max = 10;
                default: gap_max = 30;
            endcase
            if ($urandom_range(99) < 65) begin
                // load a short pattern with random content, then play it
                n = ($urandom_range(9) == 0) ? $urandom_range(40, 7) : $urandom_range(6, 1);
                for (int i = 0; i < n; i++) begin
                    if ($urandom_range(9) == 0)
                        send_load(8'($urandom_range(255)), 8'($urandom_range(255)),
                                  8'($urandom_range(255)), 8'($urandom_range(255)),
                                  short_hold());
                    send_load(8'(i), 8'($urandom_range(255)), 8'($urandom_range(255)),
                              8'($urandom_range(255)), short_hold());
                end
                case ($urandom_range(9))
                    0:       len = 0;
                    1:       len = $urandom_range(511);
                    default: len = n;
                endcase
                case ($urandom_range(9))
                    0:       rep = 0;
                    1:       rep = 32'(ENDLESS_REPEAT);
                    2:       rep = $urandom_range(255);
                    default: rep = $urandom_range(3, 1);
                endcase
                send_start(len, rep, 1'($urandom_range(1)));
                // let it play, with the odd cancel or competing start
                k = $urandom_range(30);
                for (int i = 0; i < k; i++) begin
                    case ($urandom_range(19))
                        0:       send_simple(MODE_CANCEL);
                        1:       send_start($urandom_range(n), $urandom_range(3, 1),
                                            1'($urandom_range(1)));
                        default: send_simple(MODE_TICK);
                    endcase
                end
                if ($urandom_range(2) == 0)
                    send_simple(MODE_CANCEL);
            end else begin
                // loose items of any kind
                repeat ($urandom_range(4, 1)) begin
                    m = mode_t'($urandom_range(3));
                    case (m)
                        MODE_LOAD:
                            send_load(8'($urandom_range(255)), 8'($urandom_range(255)),
                                      8'($urandom_range(255)), 8'($urandom_range(255)),
                                      16'($urandom));
                        MODE_START:
                            send_start($urandom_range(511), $urandom_range(255),
                                       1'($urandom_range(1)));
                        default:
                            send_simple(m);
                    endcase
                end
            end
        end
    endtask

    // receiver: ready pattern of its own, plus one long hold-off on request
    initial begin : result_sink
        int unsigned stall_pct;
        int unsigned left;
        m_ready   = 1'b0;
        stall_pct = 0;
        left      = 0;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                // hold off long enough for the block to back up and stall its input
                hold_request = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge aclk);
            end else begin
                if (left == 0) begin
                    case ($urandom_range(3))
                        0:       stall_pct = 0;
                        1:       stall_pct = 25;
                        2:       stall_pct = 50;
                        default: stall_pct = 85;
                    endcase
                    left = $urandom_range(256, 32);
                end
                left--;
                m_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // sample both channels at the rising edge; the input transfer is noted first
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                board.take_item(led_item_t'{mode_t'(s_mode), s_entry_index, s_level_red,
                                            s_level_green, s_level_blue, s_duration,
                                            s_pattern_length, s_repeat_count, s_urgent});
            if (m_valid && m_ready)
                board.match_frame(led_frame_t'{m_drive_red, m_drive_green, m_drive_blue,
                                               m_busy_res, status_t'(m_start_status),
                                               m_finished});
        end
    end

    // hang detector: too long without a transfer on either channel
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        wait (aresetn === 1'b1);
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    initial begin : stimulus
        board = new();

        // every input known from time zero
        aresetn          = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        s_valid          = 1'b0;
        s_mode           = MODE_TICK;
        s_entry_index    = '0;
        s_level_red      = '0;
        s_level_green    = '0;
        s_level_blue     = '0;
        s_duration       = '0;
        s_pattern_length = '0;
        s_repeat_count   = '0;
        s_urgent         = 1'b0;

        // single reset at the start of the run
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        set_enables(1'b1, 1'b1);

        // directed part
        gap_max = 2;
        send_simple(MODE_TICK);                       // tick while idle
        send_simple(MODE_CANCEL);                     // cancel while idle
        send_load(0, 8'hff, 8'h00, 8'hff, 16'h0000);  // zero duration counts as one tick
        send_load(1, 8'h00, 8'hff, 8'h00, 16'h0002);
        send_load(255, 8'h80, 8'h7f, 8'h01, 16'hffff); // top index, longest duration
        send_start(2, 2, 1'b0);                       // first entry shown at once
        send_start(2, 1, 1'b0);                       // normal start while busy: refused
        repeat (6) send_simple(MODE_TICK);            // two rounds then the drive goes off
        send_simple(MODE_TICK);
        send_load(0, 8'h12, 8'h34, 8'h56, 16'h0001);
        send_start(0, 3, 1'b0);                       // zero length ends at once
        send_start(2, 0, 1'b1);                       // zero repeat ends at once
        send_start(1, 32'(ENDLESS_REPEAT), 1'b1);     // endless playback
        repeat (2) send_simple(MODE_TICK);
        send_start(2, 3, 1'b1);                       // urgent start preempts
        send_simple(MODE_TICK);
        send_start(2, 1, 1'b0);                       // refused busy
        send_simple(MODE_CANCEL);                     // cancel switches the drive off
        send_start(511, 1, 1'b1);
        send_simple(MODE_TICK);

        // fill a whole bank and play an over-long pattern through to its saturated end,
        // with the receiver holding off meanwhile so the block backs up
        send_simple(MODE_CANCEL);
        for (int i = 0; i < PATTERN_DEPTH; i++)
            send_load(8'(i), 8'($urandom_range(255)), 8'($urandom_range(255)),
                      8'($urandom_range(255)), DURATION_BITS'($urandom_range(1)));
        send_start($urandom_range(511, PATTERN_DEPTH + 1), 1, 1'b1);
        gap_max      = 0;
        hold_request = 1'b1;
        repeat (PATTERN_DEPTH + 20) send_simple(MODE_TICK);

        // random phases across the enable settings, extremes included
        run_random(680);
        set_enables(1'b0, 1'b1);
        run_random(800);
        set_enables(1'b1, 1'b0);
        run_random(920);
        set_enables(1'b0, 1'b0);
        run_random(1000);
        set_enables(1'b1, 1'b1);
        run_random(1200);

        // wait for the last results, then a few more cycles for stray transfers
        drain();
        if (board.mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/rgblpp_pkg.sv
src/rgb_led_pattern_player.sv
tb/sv/rgblpp_check_pkg.sv
tb/sv/rgb_led_pattern_player_test.sv
